// ===== hw/rtl/ctbs_pkg.sv =====
// Shared types and constants for the CAN transmit slot scheduler.
// No dependencies; every RTL file of the block refers to it by scoped names.
package ctbs_pkg;

	localparam logic [3:0] MAX_DLC = 4'd8;

	typedef enum logic [1:0] {
		FUNC_CONFIG     = 2'd0,
		FUNC_SEND       = 2'd1,
		FUNC_TX_DONE    = 2'd2,
		FUNC_CLEAR_SYNC = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_WINDOW   = 2'd2,
		ST_ILLEGAL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_READ,
		PH_EXEC
	} phase_t;

	// One command beat.
	typedef struct packed {
		func_t       func;
		logic [3:0]  index;
		logic [10:0] ident;
		logic        rtr;
		logic [3:0]  dlc;
		logic        sync_flag;
		logic [63:0] payload;
		logic        in_window;
	} item_t;

	// One result beat.
	typedef struct packed {
		status_t     status;
		logic        report_overflow;
		logic        report_window;
		logic        frame_valid;
		logic [10:0] frame_ident;
		logic        frame_rtr;
		logic [3:0]  frame_dlc;
		logic [63:0] frame_data;
		logic        abort_request;
		logic [4:0]  pending_count;
	} result_t;

	// Per-slot setup as held in the slot memory.
	typedef struct packed {
		logic [10:0] ident;
		logic        rtr;
		logic [3:0]  len;
		logic        sync;
	} slot_meta_t;

	// Write strobes of the slot memory.
	typedef struct packed {
		logic meta;
		logic data;
	} mem_wr_t;

	// Pending-flag update for one slot.
	typedef struct packed {
		logic set;
		logic clr;
	} pend_op_t;

endpackage

// ===== hw/rtl/ctbs_slot_mem.sv =====
// Slot memory of the CAN transmit scheduler: setup words and payloads.
// Depends on ctbs_pkg for the entry and write-strobe types.
module ctbs_slot_mem #(
	parameter int SLOTS = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  ctbs_pkg::mem_wr_t   wr,
	input  logic [AW-1:0]       waddr,
	input  ctbs_pkg::slot_meta_t wmeta,
	input  logic [63:0]         wdata,
	input  logic [AW-1:0]       raddr,
	output ctbs_pkg::slot_meta_t rmeta,
	output logic [63:0]         rdata
);

	ctbs_pkg::slot_meta_t meta_mem [SLOTS];
	logic [63:0]          data_mem [SLOTS];

	// Setup and payload are written separately: configure writes the setup,
	// an accepted send writes the payload.
	always_ff @(posedge clk) begin
		if (wr.meta) begin
			meta_mem[waddr] <= wmeta;
		end
		if (wr.data) begin
			data_mem[waddr] <= wdata;
		end
		rmeta <= meta_mem[raddr];
		rdata <= data_mem[raddr];
	end

endmodule

// ===== hw/rtl/ctbs_pend_track.sv =====
// Pending flags, pending count and lowest-pending search of the scheduler.
// Depends on ctbs_pkg for the update type.
module ctbs_pend_track #(
	parameter int SLOTS = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctbs_pkg::pend_op_t  op,
	input  logic [AW-1:0]       addr,
	output logic                hit,
	output logic                any,
	output logic [AW-1:0]       first,
	output logic [CW-1:0]       count,
	output logic [CW-1:0]       count_after,
	output logic [SLOTS-1:0]    flags
);

	logic [SLOTS-1:0] pend_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (op.set) begin
				pend_q[addr] <= 1'b1;
			end
			if (op.clr) begin
				pend_q[addr] <= 1'b0;
			end
			cnt_q <= count_after;
		end
	end

	// Lowest index wins, so scan from the top down.
	always_comb begin
		first = '0;
		any   = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				first = AW'(i);
				any   = 1'b1;
			end
		end
	end

	assign hit         = pend_q[addr];
	assign count       = cnt_q;
	assign count_after = cnt_q + CW'(op.set) - CW'(op.clr);
	assign flags       = pend_q;

endmodule

// ===== hw/rtl/can_tx_buffer_scheduler.sv =====
// Top level of the CAN transmit slot scheduler with its APB register port.
// Depends on ctbs_pkg, ctbs_slot_mem and ctbs_pend_track.
//
// A command runs through the phases IDLE, READ and EXEC: the beat is captured at the edge
// where start is high and busy is low, the slot memory is read in the next
// cycle, and the cycle after that decides the outcome and writes the memory
// and the pending flags back. The slot memory read is registered, and a new
// command is only accepted once the previous one has left EXEC. The
// result beat shows on rsp for exactly one cycle, marked by done, in the cycle
// right after the decision; busy is already low in that cycle. The receiver
// cannot hold results off, so anything connected to rsp must take every beat
// in the cycle it is shown. The window check and the number of active slots
// are programmed through the APB port and should only be changed while the
// block is idle.
module can_tx_buffer_scheduler #(
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// Command channel.
	input  logic              start,
	output logic              busy,
	input  ctbs_pkg::item_t   cmd,
	// Result channel.
	output logic              done,
	output ctbs_pkg::result_t rsp,
	// Register port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// Register indexes, selected by address bit 2.
	localparam logic REG_WINDOW_CHECK = 1'b0;
	localparam logic REG_ACTIVE       = 1'b1;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic       win_chk_q;
	logic [4:0] active_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_chk_q <= 1'b0;
			active_q  <= 5'd16;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ACTIVE) begin
				active_q <= pwdata[4:0];
			end else begin
				win_chk_q <= pwdata[0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_WINDOW_CHECK) ? {31'd0, win_chk_q} : {27'd0, active_q};

	// ------------------------------------------------------------------
	// Command sequencer.
	// ------------------------------------------------------------------
	ctbs_pkg::phase_t phase_q, phase_d;
	ctbs_pkg::item_t  item_q;
	logic             accept;

	assign accept = start & ~busy;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			ctbs_pkg::PH_IDLE: begin
				if (start) begin
					phase_d = ctbs_pkg::PH_READ;
				end
			end
			ctbs_pkg::PH_READ: phase_d = ctbs_pkg::PH_EXEC;
			ctbs_pkg::PH_EXEC: phase_d = ctbs_pkg::PH_IDLE;
			default:           phase_d = ctbs_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		busy = (phase_q != ctbs_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ctbs_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// The command beat itself needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
	end

	// ------------------------------------------------------------------
	// Slot memory and pending flags.
	// ------------------------------------------------------------------
	ctbs_pkg::mem_wr_t    mem_wr;
	ctbs_pkg::slot_meta_t wmeta;
	ctbs_pkg::slot_meta_t rmeta;
	logic [63:0]          rdata;
	logic [AW-1:0]        slot_addr;
	logic [AW-1:0]        first_idx;
	logic [AW-1:0]        pend_addr;
	ctbs_pkg::pend_op_t   pend_op;
	logic                 pend_hit;
	logic                 pend_any;
	logic [CW-1:0]        pend_cnt;
	logic [CW-1:0]        pend_cnt_after;
	logic [SLOTS-1:0]     pend_flags;
	logic                 is_tx_done;

	assign slot_addr  = AW'(item_q.index);
	assign is_tx_done = (item_q.func == ctbs_pkg::FUNC_TX_DONE);

	// Transmit complete works on the lowest pending slot; the pending flags
	// do not change between the read and the decision, so the same search
	// result serves both cycles.
	assign pend_addr = is_tx_done ? first_idx : slot_addr;

	assign wmeta.ident = item_q.ident;
	assign wmeta.rtr   = item_q.rtr;
	assign wmeta.len   = item_q.dlc;
	assign wmeta.sync  = item_q.sync_flag;

	// Each command finishes its write-back before the next one can read,
	// so no forwarding is needed around the memory.
	ctbs_slot_mem #(
		.SLOTS (SLOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.waddr (slot_addr),
		.wmeta (wmeta),
		.wdata (item_q.payload),
		.raddr (pend_addr),
		.rmeta (rmeta),
		.rdata (rdata)
	);

	ctbs_pend_track #(
		.SLOTS (SLOTS),
		.AW    (AW),
		.CW    (CW)
	) u_pend (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (pend_op),
		.addr        (pend_addr),
		.hit         (pend_hit),
		.any         (pend_any),
		.first       (first_idx),
		.count       (pend_cnt),
		.count_after (pend_cnt_after),
		.flags       (pend_flags)
	);

	// ------------------------------------------------------------------
	// Decision cycle.
	// ------------------------------------------------------------------
	logic              hw_busy_q, hw_busy_d;
	logic              inhibit_q, inhibit_d;
	logic              first_q, first_d;
	ctbs_pkg::result_t res_d;
	ctbs_pkg::result_t res_q;
	logic              done_q;
	logic              idx_ok;
	logic              load;
	logic              load_direct;
	logic [3:0]        load_len;
	logic [63:0]       load_src;
	logic              exec;

	assign exec = (phase_q == ctbs_pkg::PH_EXEC);

	// Legal slots are below both the programmed count and the table size.
	assign idx_ok = ({1'b0, item_q.index} < active_q) && (32'(item_q.index) < SLOTS);

	always_comb begin
		res_d       = '0;
		mem_wr      = '0;
		pend_op     = '0;
		hw_busy_d   = hw_busy_q;
		inhibit_d   = inhibit_q;
		first_d     = first_q;
		load        = 1'b0;
		load_direct = 1'b0;
		case (item_q.func)
			ctbs_pkg::FUNC_CONFIG: begin
				if (!idx_ok) begin
					res_d.status = ctbs_pkg::ST_ILLEGAL;
				end else begin
					// Reconfiguring a waiting slot drops it from the queue.
					mem_wr.meta = exec;
					pend_op.clr = exec & pend_hit;
				end
			end
			ctbs_pkg::FUNC_SEND: begin
				if (!idx_ok) begin
					res_d.status = ctbs_pkg::ST_ILLEGAL;
				end else if (pend_hit) begin
					// Overflow is only reported once a frame has gone out.
					res_d.status          = ctbs_pkg::ST_OVERFLOW;
					res_d.report_overflow = ~first_q;
				end else if (win_chk_q && rmeta.sync && !item_q.in_window) begin
					res_d.status        = ctbs_pkg::ST_WINDOW;
					res_d.report_window = 1'b1;
				end else begin
					mem_wr.data = exec;
					if (!hw_busy_q && (pend_cnt == '0)) begin
						load        = 1'b1;
						load_direct = 1'b1;
						inhibit_d   = rmeta.sync;
					end else begin
						pend_op.set = exec;
					end
				end
			end
			ctbs_pkg::FUNC_TX_DONE: begin
				first_d   = 1'b0;
				inhibit_d = 1'b0;
				hw_busy_d = 1'b0;
				if (pend_any) begin
					pend_op.clr = exec;
					if (win_chk_q && rmeta.sync && !item_q.in_window) begin
						res_d.status        = ctbs_pkg::ST_WINDOW;
						res_d.report_window = 1'b1;
					end else begin
						load      = 1'b1;
						inhibit_d = win_chk_q & rmeta.sync;
					end
				end
			end
			ctbs_pkg::FUNC_CLEAR_SYNC: begin
				if (inhibit_q) begin
					res_d.status        = ctbs_pkg::ST_WINDOW;
					res_d.report_window = 1'b1;
					res_d.abort_request = 1'b1;
					hw_busy_d           = 1'b0;
					inhibit_d           = 1'b0;
				end
			end
			default: begin
				res_d.status = ctbs_pkg::ST_OK;
			end
		endcase

		// A loaded frame carries at most eight bytes; bytes past the
		// clamped length read as zero.
		load_len = (rmeta.len > ctbs_pkg::MAX_DLC) ? ctbs_pkg::MAX_DLC : rmeta.len;
		load_src = load_direct ? item_q.payload : rdata;
		if (load) begin
			hw_busy_d         = 1'b1;
			res_d.frame_valid = 1'b1;
			res_d.frame_ident = rmeta.ident;
			res_d.frame_rtr   = rmeta.rtr;
			res_d.frame_dlc   = load_len;
			for (int b = 0; b < 8; b++) begin
				res_d.frame_data[8*b +: 8] = (4'(b) < load_len) ? load_src[8*b +: 8] : 8'd0;
			end
		end
		res_d.pending_count = 5'(pend_cnt_after);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_busy_q <= 1'b0;
			inhibit_q <= 1'b0;
			first_q   <= 1'b1;
			done_q    <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) begin
				hw_busy_q <= hw_busy_d;
				inhibit_q <= inhibit_d;
				first_q   <= first_d;
			end
		end
	end

	// The result register holds data only; done marks it.
	always_ff @(posedge clk) begin
		if (exec) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign rsp  = res_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A result beat follows exactly one decision cycle.
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(phase_q == ctbs_pkg::PH_EXEC))
		else $error("result beat without a decision cycle");

	// The pending count always matches the number of pending flags.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt == CW'($countones(pend_flags)))
		else $error("pending count out of step with pending flags");

	// A loaded frame leaves the hardware buffer marked busy.
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.frame_valid) |-> hw_busy_q)
		else $error("frame loaded but hardware buffer not busy");

	// An abort is only raised while a sync frame was inhibited, and it
	// releases the inhibit.
	a_abort_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.abort_request) |-> (!inhibit_q && $past(inhibit_q, 2)))
		else $error("abort without an inhibited sync frame");

endmodule

// ===== dv/tb_can_tx_buffer_scheduler.sv =====
// Self-checking testbench for can_tx_buffer_scheduler: command beats in, one result beat out
// per command, compared with an in-bench scoreboard that tracks the slot table and buffer.
// Depends on ctbs_pkg and the can_tx_buffer_scheduler RTL.
module tb_can_tx_buffer_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS     = 16;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int PHASE_CMDS    = 75;
	localparam int NUM_PHASES    = 6;
	// Cycles to let pass after the last result before touching the registers or
	// ending the run.
	localparam int SETTLE_CYCLES = 6;
	// Cycles without any accepted beat before the run is declared hung.
	localparam int IDLE_LIMIT    = 1000;

	localparam logic [2:0] ADDR_WIN_CHECK = 3'd0;
	localparam logic [2:0] ADDR_ACTIVE    = 3'd4;

	// Scoreboard: keeps its own copy of the slot table, the pending flags and the
	// hardware buffer state, predicts one result beat per accepted command and
	// checks result beats against those predictions in order.
	class can_frame_scoreboard;
		logic [10:0] ident_tbl [NUM_SLOTS];
		logic        rtr_tbl [NUM_SLOTS];
		logic [3:0]  len_tbl [NUM_SLOTS];
		logic        sync_tbl [NUM_SLOTS];
		logic [63:0] data_tbl [NUM_SLOTS];
		bit [NUM_SLOTS-1:0] queued;
		bit [4:0]    queued_total;
		bit          buffer_full;
		bit          inhibit;
		bit          no_frame_done;
		bit          win_check;
		bit [4:0]    active_slots;
		ctbs_pkg::result_t expected_q[$];
		int          mismatches;

		function new();
			queued        = '0;
			queued_total  = '0;
			buffer_full   = 1'b0;
			inhibit       = 1'b0;
			no_frame_done = 1'b1;
			win_check     = 1'b0;
			active_slots  = 5'd16;
			mismatches    = 0;
		endfunction

		function void set_regs(bit chk, bit [4:0] act);
			win_check    = chk;
			active_slots = act;
		endfunction

		// Puts slot s into the hardware buffer; bytes at or above the clamped
		// length are cleared.
		function ctbs_pkg::result_t with_frame(ctbs_pkg::result_t r, int s);
			logic [3:0]  n;
			logic [63:0] mask;
			n    = (len_tbl[s] > ctbs_pkg::MAX_DLC) ? ctbs_pkg::MAX_DLC : len_tbl[s];
			mask = (n >= ctbs_pkg::MAX_DLC) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
			r.frame_valid = 1'b1;
			r.frame_ident = ident_tbl[s];
			r.frame_rtr   = rtr_tbl[s];
			r.frame_dlc   = n;
			r.frame_data  = data_tbl[s] & mask;
			buffer_full   = 1'b1;
			return r;
		endfunction

		function void note_command(ctbs_pkg::item_t c);
			ctbs_pkg::result_t r;
			int      lim;
			bit      found;
			r     = '0;
			lim   = (active_slots < NUM_SLOTS) ? int'(active_slots) : NUM_SLOTS;
			found = 1'b0;
			case (c.func)
				ctbs_pkg::FUNC_CONFIG, ctbs_pkg::FUNC_SEND: begin
					if (int'(c.index) >= lim) begin
						r.status = ctbs_pkg::ST_ILLEGAL;
					end else if (c.func == ctbs_pkg::FUNC_CONFIG) begin
						// Reconfiguring a waiting slot drops it from the queue.
						if (queued[c.index]) begin
							queued[c.index] = 1'b0;
							queued_total--;
						end
						ident_tbl[c.index] = c.ident;
						rtr_tbl[c.index]   = c.rtr;
						len_tbl[c.index]   = c.dlc;
						sync_tbl[c.index]  = c.sync_flag;
					end else if (queued[c.index]) begin
						r.status          = ctbs_pkg::ST_OVERFLOW;
						r.report_overflow = !no_frame_done;
					end else if (win_check && sync_tbl[c.index] && !c.in_window) begin
						r.status        = ctbs_pkg::ST_WINDOW;
						r.report_window = 1'b1;
					end else begin
						data_tbl[c.index] = c.payload;
						if (!buffer_full && queued_total == 5'd0) begin
							inhibit = sync_tbl[c.index];
							r = with_frame(r, int'(c.index));
						end else begin
							queued[c.index] = 1'b1;
							queued_total++;
						end
					end
				end
				ctbs_pkg::FUNC_TX_DONE: begin
					no_frame_done = 1'b0;
					inhibit       = 1'b0;
					buffer_full   = 1'b0;
					// Lowest waiting slot over the whole table, whatever the active count.
					for (int s = 0; s < NUM_SLOTS; s++) begin
						if (!found && queued[s]) begin
							found     = 1'b1;
							queued[s] = 1'b0;
							queued_total--;
							if (win_check && sync_tbl[s] && !c.in_window) begin
								r.status        = ctbs_pkg::ST_WINDOW;
								r.report_window = 1'b1;
							end else begin
								if (win_check && sync_tbl[s])
									inhibit = 1'b1;
								r = with_frame(r, s);
							end
						end
					end
				end
				default: begin
					if (inhibit) begin
						r.status        = ctbs_pkg::ST_WINDOW;
						r.report_window = 1'b1;
						r.abort_request = 1'b1;
						buffer_full     = 1'b0;
						inhibit         = 1'b0;
					end
				end
			endcase
			r.pending_count = queued_total;
			expected_q.push_back(r);
		endfunction

		function void check_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_beat(ctbs_pkg::result_t got);
			ctbs_pkg::result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, expected none, actual %p",
					$time, got);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_field("status", 64'(want.status), 64'(got.status));
				check_field("report_overflow", 64'(want.report_overflow),
					64'(got.report_overflow));
				check_field("report_window", 64'(want.report_window),
					64'(got.report_window));
				check_field("frame_valid", 64'(want.frame_valid), 64'(got.frame_valid));
				check_field("frame_ident", 64'(want.frame_ident), 64'(got.frame_ident));
				check_field("frame_rtr", 64'(want.frame_rtr), 64'(got.frame_rtr));
				check_field("frame_dlc", 64'(want.frame_dlc), 64'(got.frame_dlc));
				check_field("frame_data", want.frame_data, got.frame_data);
				check_field("abort_request", 64'(want.abort_request),
					64'(got.abort_request));
				check_field("pending_count", 64'(want.pending_count),
					64'(got.pending_count));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	ctbs_pkg::item_t   cmd;
	logic        done;
	ctbs_pkg::result_t rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	can_frame_scoreboard board;

	// Stimulus-side view of the slot table: a send to an active slot is only
	// issued once that slot has been configured, since its setup is unknown before.
	bit slot_known [NUM_SLOTS];
	int cur_limit = NUM_SLOTS;
	int burst_left = 0;
	int idle_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	can_tx_buffer_scheduler #(
		.SLOTS(NUM_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Monitor: everything is sampled at the rising edge, where inputs driven on
	// the falling edge are stable. A command beat is taken when start is high and
	// busy is low; a result beat is taken whenever done is high, since the block
	// shows each one for a single cycle only.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_beat(rsp);
			if (start && !busy)
				board.note_command(cmd);
		end
	end

	// Watchdog: a stretch of cycles with neither a command nor a result beat
	// means the block has hung or dropped a result.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("can_tx_buffer_scheduler verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Presents one command beat from a falling edge and holds it until the block
	// takes it. Returns on the following falling edge with start still high, so
	// the caller either presents the next beat or drops start in that same step.
	task automatic issue(input ctbs_pkg::item_t c);
		if (c.func == ctbs_pkg::FUNC_CONFIG && int'(c.index) < cur_limit)
			slot_known[c.index] = 1'b1;
		cmd   = c;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause(input int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Sender pacing: bursts of random length, mostly short, now and then long
	// enough to run the block flat out, separated by random gaps so the gaps
	// land on every phase of the command pipeline.
	task automatic issue_paced(input ctbs_pkg::item_t c);
		if (burst_left == 0) begin
			pause(int'($urandom_range(1, 6)));
			burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(15, 40))
				: int'($urandom_range(1, 6));
		end
		issue(c);
		burst_left--;
	endtask

	// Stops sending and waits until every predicted result has come back, then
	// lets the pipeline settle.
	task automatic drain();
		start = 1'b0;
		while (board.expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Registers are only changed with the block idle and nothing in flight.
	task automatic program_regs(input bit chk, input bit [4:0] act);
		drain();
		reg_write(ADDR_WIN_CHECK, {31'd0, chk});
		reg_write(ADDR_ACTIVE, {27'd0, act});
		board.set_regs(chk, act);
		cur_limit = (act < NUM_SLOTS) ? int'(act) : NUM_SLOTS;
	endtask

	function automatic ctbs_pkg::item_t make_cmd(ctbs_pkg::func_t f, logic [3:0] idx,
		logic [10:0] id, logic rtr, logic [3:0] dlc, logic sync, logic [63:0] data,
		logic win);
		ctbs_pkg::item_t c;
		c.func      = f;
		c.index     = idx;
		c.ident     = id;
		c.rtr       = rtr;
		c.dlc       = dlc;
		c.sync_flag = sync;
		c.payload   = data;
		c.in_window = win;
		return c;
	endfunction

	// Random command: mostly sends and transmit completions on active slots so
	// the queue fills and drains, with configures (which also drop waiting
	// slots), clear-sync requests and a share of illegal indexes as noise.
	function automatic ctbs_pkg::item_t random_command();
		ctbs_pkg::item_t c;
		int    pick;
		pick        = int'($urandom_range(0, 99));
		c.ident     = 11'($urandom);
		c.rtr       = 1'($urandom_range(0, 1));
		c.dlc       = 4'($urandom);
		c.sync_flag = 1'($urandom_range(0, 1));
		c.payload   = {$urandom, $urandom};
		c.in_window = ($urandom_range(0, 3) != 0);
		if (pick < 20)
			c.func = ctbs_pkg::FUNC_CONFIG;
		else if (pick < 60)
			c.func = ctbs_pkg::FUNC_SEND;
		else if (pick < 88)
			c.func = ctbs_pkg::FUNC_TX_DONE;
		else
			c.func = ctbs_pkg::FUNC_CLEAR_SYNC;
		if (cur_limit < NUM_SLOTS && $urandom_range(0, 9) == 0)
			c.index = 4'($urandom_range(cur_limit, NUM_SLOTS - 1));
		else
			c.index = 4'($urandom_range(0, cur_limit - 1));
		// A send to a slot whose setup is still unknown becomes its configure.
		if (c.func == ctbs_pkg::FUNC_SEND && int'(c.index) < cur_limit
			&& !slot_known[c.index])
			c.func = ctbs_pkg::FUNC_CONFIG;
		return c;
	endfunction

	bit       phase_chk [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	bit [4:0] phase_act [NUM_PHASES] = '{5'd16, 5'd16, 5'd1, 5'd1, 5'd10, 5'd7};

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		cmd     = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		board   = new();
		foreach (slot_known[i])
			slot_known[i] = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, registers at their reset values: window check off,
		// all sixteen slots active.
		issue_paced(make_cmd(ctbs_pkg::FUNC_CONFIG, 4'd0, 11'h7FF, 1'b1, 4'hF, 1'b0, '0,
			1'b1));
		issue_paced(make_cmd(ctbs_pkg::FUNC_CONFIG, 4'd15, 11'h000, 1'b0, 4'h0, 1'b1, '0,
			1'b0));
		issue_paced(make_cmd(ctbs_pkg::FUNC_CONFIG, 4'd5, 11'h2AA, 1'b0, 4'h3, 1'b0, '0,
			1'b1));
		// Direct load with the length clamped to eight bytes.
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd0, '0, 1'b0, 4'h0, 1'b0, '1, 1'b1));
		// Buffer busy: the slot goes into the queue.
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd5, '0, 1'b0, 4'h0, 1'b0,
			64'h0123_4567_89AB_CDEF, 1'b0));
		// Overflow before any frame has completed: not reported.
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd5, '0, 1'b0, 4'h0, 1'b0, '1, 1'b1));
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd15, '0, 1'b0, 4'h0, 1'b0,
			64'hFEDC_BA98_7654_3210, 1'b1));
		// Nothing inhibited: clear-sync does nothing.
		issue_paced(make_cmd(ctbs_pkg::FUNC_CLEAR_SYNC, 4'd0, '0, 1'b0, 4'h0, 1'b0, '0,
			1'b1));
		// Lowest waiting slot is loaded, data masked to three bytes.
		issue_paced(make_cmd(ctbs_pkg::FUNC_TX_DONE, 4'd0, '0, 1'b0, 4'h0, 1'b0, '0,
			1'b1));
		// Overflow after the first frame: reported.
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd15, '0, 1'b0, 4'h0, 1'b0, '0, 1'b1));
		// Reconfigure of a waiting slot drops it.
		issue_paced(make_cmd(ctbs_pkg::FUNC_CONFIG, 4'd15, 11'h555, 1'b1, 4'h8, 1'b1, '0,
			1'b0));
		// Completion with an empty queue.
		issue_paced(make_cmd(ctbs_pkg::FUNC_TX_DONE, 4'd0, '0, 1'b0, 4'h0, 1'b0, '0,
			1'b0));
		// Direct load of a sync slot sets the inhibit; clear-sync aborts it once.
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd15, '0, 1'b0, 4'h0, 1'b0, '0, 1'b1));
		issue_paced(make_cmd(ctbs_pkg::FUNC_CLEAR_SYNC, 4'd0, '0, 1'b0, 4'h0, 1'b0, '0,
			1'b1));
		issue_paced(make_cmd(ctbs_pkg::FUNC_CLEAR_SYNC, 4'd0, '0, 1'b0, 4'h0, 1'b0, '0,
			1'b1));
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd0, '0, 1'b0, 4'h0, 1'b0,
			64'hA5A5_5A5A_0F0F_F0F0, 1'b1));
		// Leave slot 15 waiting across the change to a single active slot.
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd15, '0, 1'b0, 4'h0, 1'b0,
			64'h1122_3344_5566_7788, 1'b0));

		// Window check on, only slot 0 active.
		program_regs(1'b1, 5'd1);
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd5, '0, 1'b0, 4'h0, 1'b0, '1, 1'b1));
		issue_paced(make_cmd(ctbs_pkg::FUNC_CONFIG, 4'd9, 11'h7FF, 1'b1, 4'hF, 1'b1, '0,
			1'b1));
		issue_paced(make_cmd(ctbs_pkg::FUNC_CONFIG, 4'd0, 11'h123, 1'b0, 4'h9, 1'b1, '0,
			1'b1));
		// Sync send outside the window is refused.
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd0, '0, 1'b0, 4'h0, 1'b0, '1, 1'b0));
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd0, '0, 1'b0, 4'h0, 1'b0,
			64'hCAFE_F00D_DEAD_BEEF, 1'b1));
		// Slot 0 is the lowest waiting slot: it is loaded and, being a sync slot
		// with the check on, sets the inhibit.
		issue_paced(make_cmd(ctbs_pkg::FUNC_TX_DONE, 4'd0, '0, 1'b0, 4'h0, 1'b0, '0,
			1'b1));
		// Slot 15 is still released although it lies above the active count; as a
		// sync slot out of the window it is dropped.
		issue_paced(make_cmd(ctbs_pkg::FUNC_TX_DONE, 4'd0, '0, 1'b0, 4'h0, 1'b0, '0,
			1'b0));
		issue_paced(make_cmd(ctbs_pkg::FUNC_SEND, 4'd0, '0, 1'b0, 4'h0, 1'b0,
			64'h0000_0000_FFFF_FFFF, 1'b1));
		issue_paced(make_cmd(ctbs_pkg::FUNC_CLEAR_SYNC, 4'd0, '0, 1'b0, 4'h0, 1'b0, '0,
			1'b1));

		// Random part: several register settings, the extremes among them; each
		// change waits until the block has answered everything.
		for (int p = 0; p < NUM_PHASES; p++) begin
			program_regs(phase_chk[p], phase_act[p]);
			repeat (PHASE_CMDS)
				issue_paced(random_command());
		end

		drain();
		if (board.mismatches == 0 && board.expected_q.size() == 0) begin
			$display("can_tx_buffer_scheduler verification clean");
		end else begin
			$display("can_tx_buffer_scheduler verification failed");
		end
		$finish;
	end

endmodule
